FILE: rtl/v3mu_pkg.sv
`timescale 1ns / 1ps
package v3mu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HMAX      = 31 - FRAC_BITS;
  localparam int HW        = $clog2(HMAX + 1);
  localparam int QW        = FRAC_BITS + 1;
  localparam int SQS       = 32;

  localparam logic [3:0] MODE_ADD   = 4'd0;
  localparam logic [3:0] MODE_SUB   = 4'd1;
  localparam logic [3:0] MODE_NEG   = 4'd2;
  localparam logic [3:0] MODE_SCALE = 4'd3;
  localparam logic [3:0] MODE_ADDK  = 4'd4;
  localparam logic [3:0] MODE_ELEM  = 4'd5;
  localparam logic [3:0] MODE_CROSS = 4'd6;
  localparam logic [3:0] MODE_DOT   = 4'd7;
  localparam logic [3:0] MODE_MAG   = 4'd8;
  localparam logic [3:0] MODE_DIST  = 4'd9;
  localparam logic [3:0] MODE_NORM  = 4'd10;

  localparam logic [31:0] MAX32 = 32'h7fffffff;
  localparam logic [31:0] MIN32 = 32'h80000000;
  localparam logic signed [67:0] SMAX68 = 68'sd2147483647;
  localparam logic signed [67:0] SMIN68 = -68'sd2147483648;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic signed [65:0] p0;
    logic signed [63:0] p1;
    logic [31:0]        simple;
    logic               sov;
    logic               big;
  } lane_out_t;

  typedef struct packed {
    logic [3:0]    mode;
    vec3_t         a;
    vec3_t         res;
    logic          ov;
    logic          big;
    logic [HW-1:0] h;
    logic [31:0]   mag;
    logic          magov;
  } side_t;

  // {overflow, value}
  function automatic logic [32:0] sat32(input logic signed [67:0] v);
    logic [32:0] r;
    if (v > SMAX68) begin
      r = {1'b1, MAX32};
    end else if (v < SMIN68) begin
      r = {1'b1, MIN32};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/v3mu_in_if.sv
`timescale 1ns / 1ps
interface v3mu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar_k;

  modport source (output valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_k, input ready);
  modport sink (input valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_k, output ready);
endinterface

FILE: rtl/v3mu_out_if.sv
`timescale 1ns / 1ps
interface v3mu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic               zero_length;
  logic               overflow;

  modport source (output valid, res_x, res_y, res_z, zero_length, overflow, input ready);
  modport sink (input valid, res_x, res_y, res_z, zero_length, overflow, output ready);
endinterface

FILE: rtl/v3mu_lane.sv
`timescale 1ns / 1ps
module v3mu_lane (
  input  logic                clk,
  input  logic                en,
  input  logic [3:0]          mode,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  logic [31:0]         k,
  input  logic [31:0]         a_j,
  input  logic [31:0]         b_m,
  input  logic [31:0]         a_m,
  input  logic [31:0]         b_j,
  output v3mu_pkg::lane_out_t q
);
  import v3mu_pkg::*;

  logic signed [32:0] a33, b33, k33, d, sum, op0, op1;
  logic [32:0]        st;
  lane_out_t          q_nxt, q_r;

  always_comb begin
    a33 = {a_i[31], a_i};
    b33 = {b_i[31], b_i};
    k33 = {k[31], k};
    d   = (mode == MODE_DIST) ? (a33 - b33) : a33;
    case (mode)
      MODE_ADD:  sum = a33 + b33;
      MODE_SUB:  sum = a33 - b33;
      MODE_NEG:  sum = -a33;
      MODE_ADDK: sum = a33 + k33;
      default:   sum = '0;
    endcase
    st = sat32({{35{sum[32]}}, sum});
    case (mode)
      MODE_SCALE: begin
        op0 = a33;
        op1 = k33;
      end
      MODE_ELEM, MODE_DOT: begin
        op0 = a33;
        op1 = b33;
      end
      MODE_CROSS: begin
        op0 = {a_j[31], a_j};
        op1 = {b_m[31], b_m};
      end
      MODE_MAG, MODE_DIST, MODE_NORM: begin
        op0 = d;
        op1 = d;
      end
      default: begin
        op0 = '0;
        op1 = '0;
      end
    endcase
    q_nxt.p0     = op0 * op1;
    q_nxt.p1     = $signed(a_m) * $signed(b_j);
    q_nxt.simple = st[31:0];
    q_nxt.sov    = st[32];
    q_nxt.big    = (d > 33'sd2147483648) || (d < -33'sd2147483648);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/v3mu_merge.sv
`timescale 1ns / 1ps
module v3mu_merge (
  input  logic                  clk,
  input  logic                  en_a,
  input  logic                  en_b,
  input  logic [3:0]            mode_a,
  input  logic [3:0]            mode_b,
  input  v3mu_pkg::lane_out_t   ln [3],
  output v3mu_pkg::vec3_t       res,
  output logic                  ov,
  output logic                  big,
  output logic [v3mu_pkg::HW-1:0] h,
  output logic [63:0]           sqin
);
  import v3mu_pkg::*;

  localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);

  logic signed [67:0] e [3];
  logic signed [67:0] dsum;
  logic signed [67:0] pr_nxt [3];
  logic signed [67:0] pr_r [3];
  logic [63:0]        sq_nxt, sq_r;
  vec3_t              simp_r;
  logic [2:0]         sov_r;
  logic               bga_r;

  logic signed [67:0] rnd;
  logic [32:0]        st;
  vec3_t              res_nxt, res_r;
  logic               ov_nxt, ov_r, big_r;
  logic [HW-1:0]      h_nxt, h_r;
  logic [63:0]        sqin_nxt, sqin_r;

  // sums and differences of lane products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e[i] = {{2{ln[i].p0[65]}}, ln[i].p0};
    end
    dsum   = e[0] + e[1] + e[2];
    sq_nxt = ln[0].p0[63:0] + ln[1].p0[63:0] + ln[2].p0[63:0];
    for (int i = 0; i < 3; i++) begin
      case (mode_a)
        MODE_CROSS: pr_nxt[i] = e[i] - {{4{ln[i].p1[63]}}, ln[i].p1};
        MODE_DOT:   pr_nxt[i] = (i == 0) ? dsum : '0;
        default:    pr_nxt[i] = e[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[i]   <= pr_nxt[i];
        simp_r[i] <= ln[i].simple;
        sov_r[i]  <= ln[i].sov;
      end
      sq_r  <= sq_nxt;
      bga_r <= ln[0].big | ln[1].big | ln[2].big;
    end
  end

  // rounding, saturation and root prescale
  always_comb begin
    res_nxt = '0;
    ov_nxt  = 1'b0;
    rnd     = '0;
    st      = '0;
    for (int i = 0; i < 3; i++) begin
      rnd = (pr_r[i] + HALF) >>> FRAC_BITS;
      st  = sat32(rnd);
      case (mode_b)
        MODE_SCALE, MODE_ELEM, MODE_CROSS, MODE_DOT: begin
          res_nxt[i] = st[31:0];
          ov_nxt     = ov_nxt | st[32];
        end
        MODE_ADD, MODE_SUB, MODE_NEG, MODE_ADDK: begin
          res_nxt[i] = simp_r[i];
          ov_nxt     = ov_nxt | sov_r[i];
        end
        default: ;
      endcase
    end
    h_nxt = HW'(HMAX);
    for (int hh = HMAX - 1; hh >= 0; hh--) begin
      if ((sq_r >> (62 - 2 * hh)) != 64'd0) begin
        h_nxt = HW'(hh);
      end
    end
    sqin_nxt = (mode_b == MODE_NORM) ? (sq_r << {h_nxt, 1'b0}) : sq_r;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      res_r  <= res_nxt;
      ov_r   <= ov_nxt;
      big_r  <= bga_r;
      h_r    <= h_nxt;
      sqin_r <= sqin_nxt;
    end
  end

  assign res  = res_r;
  assign ov   = ov_r;
  assign big  = big_r;
  assign h    = h_r;
  assign sqin = sqin_r;

endmodule

FILE: rtl/v3mu_sqrt.sv
`timescale 1ns / 1ps
module v3mu_sqrt (
  input  logic                     clk,
  input  logic [v3mu_pkg::SQS-1:0] en,
  input  logic [63:0]              s,
  output logic [31:0]              root,
  output logic [63:0]              rem
);
  import v3mu_pkg::*;

  logic [31:0] r_r [SQS];
  logic [63:0] m_r [SQS];

  // one root bit per stage, msb first
  for (genvar t = 0; t < SQS; t++) begin : g_stg
    localparam int J = SQS - 1 - t;
    logic [31:0] pr;
    logic [63:0] pm;
    logic [65:0] trial;
    logic        ge;

    if (t == 0) begin : g_first
      assign pr = '0;
      assign pm = s;
    end else begin : g_next
      assign pr = r_r[t-1];
      assign pm = m_r[t-1];
    end

    always_comb begin
      trial = ({34'd0, pr} << (J + 1)) | (66'd1 << (2 * J));
      ge    = {2'b00, pm} >= trial;
    end

    always_ff @(posedge clk) begin
      if (en[t]) begin
        r_r[t] <= ge ? (pr | (32'd1 << J)) : pr;
        m_r[t] <= ge ? (pm - trial[63:0]) : pm;
      end
    end
  end

  assign root = r_r[SQS-1];
  assign rem  = m_r[SQS-1];

endmodule

FILE: rtl/v3mu_div.sv
`timescale 1ns / 1ps
module v3mu_div (
  input  logic                    clk,
  input  logic [v3mu_pkg::QW-1:0] en,
  input  logic [63:0]             num,
  input  logic [31:0]             den,
  output logic [v3mu_pkg::QW-1:0] q
);
  import v3mu_pkg::*;

  logic [63:0]   m_r [QW];
  logic [QW-1:0] q_r [QW];
  logic [31:0]   d_r [QW];

  // restoring division, one quotient bit per stage
  for (genvar t = 0; t < QW; t++) begin : g_stg
    localparam int J = QW - 1 - t;
    logic [63:0]   pm;
    logic [QW-1:0] pq;
    logic [31:0]   pd;
    logic [63:0]   trial;
    logic          ge;

    if (t == 0) begin : g_first
      assign pm = num;
      assign pq = '0;
      assign pd = den;
    end else begin : g_next
      assign pm = m_r[t-1];
      assign pq = q_r[t-1];
      assign pd = d_r[t-1];
    end

    always_comb begin
      trial = {32'd0, pd} << J;
      ge    = pm >= trial;
    end

    always_ff @(posedge clk) begin
      if (en[t]) begin
        m_r[t] <= ge ? (pm - trial) : pm;
        q_r[t] <= ge ? (pq | (QW'(1) << J)) : pq;
        d_r[t] <= pd;
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

FILE: rtl/vector3_math_unit.sv
`timescale 1ns / 1ps
// channel   | dir | contents
// in_req    | in  | mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_k
// out_res   | out | res_x, res_y, res_z, zero_length, overflow
//
// one request per cycle while in_req.ready is high; the pipeline depth is set by the
// 32-stage square root at Q16.16 and by the per-lane divider stages
// reset clears only the stage valid bits
// a stalled output holds its stage; earlier empty stages keep filling, so
// in_req.ready drops only when every stage holds a request
module vector3_math_unit (
  input  logic         clk,
  input  logic         rst_n,
  v3mu_in_if.sink      in_req,
  v3mu_out_if.source   out_res
);
  import v3mu_pkg::*;

  localparam int ST_LANE = 1;
  localparam int ST_MA   = 2;
  localparam int ST_MB   = 3;
  localparam int ST_SQ   = 4;
  localparam int ST_POST = ST_SQ + SQS;
  localparam int ST_DIV  = ST_POST + 1;
  localparam int ST_OUT  = ST_DIV + QW;
  localparam int NST     = ST_OUT + 1;

  logic [NST-1:0] v_r, v_nxt, en;

  side_t       side_in;
  side_t       side_r [ST_OUT];
  vec3_t       b_r;
  logic [31:0] k_r;

  lane_out_t     ln [3];
  vec3_t         mg_res;
  logic          mg_ov, mg_big;
  logic [HW-1:0] mg_h;
  logic [63:0]   mg_sqin;
  logic [31:0]   sq_root;
  logic [63:0]   sq_rem;

  logic [32:0]   rr;
  logic [31:0]   mag_nxt;
  logic          magov_nxt;
  logic [63:0]   num_nxt [3];
  logic [63:0]   num_r [3];
  logic [31:0]   den_r;
  logic [31:0]   am [3];
  logic [QW-1:0] dq [3];

  side_t       sd;
  logic        zero_vec;
  logic [31:0] qv;
  vec3_t       o_res_nxt, o_res_r;
  logic        o_zl_nxt, o_zl_r, o_ov_nxt, o_ov_r;

  // stage handshake
  assign en[NST-1] = !v_r[NST-1] || out_res.ready;
  for (genvar s = 0; s < NST - 1; s++) begin : g_en
    assign en[s] = !v_r[s] || en[s+1];
  end
  assign v_nxt        = {v_r[NST-2:0], in_req.valid};
  assign in_req.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (en[s]) begin
          v_r[s] <= v_nxt[s];
        end
      end
    end
  end

  // request capture
  always_comb begin
    side_in      = '0;
    side_in.mode = in_req.mode;
    side_in.a    = {in_req.a_z, in_req.a_y, in_req.a_x};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_in;
      b_r       <= {in_req.b_z, in_req.b_y, in_req.b_x};
      k_r       <= in_req.scalar_k;
    end
  end

  // side data travels with each request
  for (genvar s = 1; s < ST_OUT; s++) begin : g_side
    side_t side_nxt;
    always_comb begin
      side_nxt = side_r[s-1];
      if (s == ST_SQ) begin
        side_nxt.res = mg_res;
        side_nxt.ov  = mg_ov;
        side_nxt.big = mg_big;
        side_nxt.h   = mg_h;
      end
      if (s == ST_POST) begin
        side_nxt.mag   = mag_nxt;
        side_nxt.magov = magov_nxt;
      end
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        side_r[s] <= side_nxt;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int M = (i + 2) % 3;
    v3mu_lane u_lane (
      .clk  (clk),
      .en   (en[ST_LANE]),
      .mode (side_r[0].mode),
      .a_i  (side_r[0].a[i]),
      .b_i  (b_r[i]),
      .k    (k_r),
      .a_j  (side_r[0].a[J]),
      .b_m  (b_r[M]),
      .a_m  (side_r[0].a[M]),
      .b_j  (b_r[J]),
      .q    (ln[i])
    );
  end

  v3mu_merge u_merge (
    .clk    (clk),
    .en_a   (en[ST_MA]),
    .en_b   (en[ST_MB]),
    .mode_a (side_r[ST_LANE].mode),
    .mode_b (side_r[ST_MA].mode),
    .ln     (ln),
    .res    (mg_res),
    .ov     (mg_ov),
    .big    (mg_big),
    .h      (mg_h),
    .sqin   (mg_sqin)
  );

  v3mu_sqrt u_sqrt (
    .clk  (clk),
    .en   (en[ST_POST-1:ST_SQ]),
    .s    (mg_sqin),
    .root (sq_root),
    .rem  (sq_rem)
  );

  // root rounding and normalize numerators
  always_comb begin
    rr = {1'b0, sq_root} + {32'd0, (sq_rem > {32'd0, sq_root})};
    if (side_r[ST_POST-1].big || (rr > {1'b0, MAX32})) begin
      mag_nxt   = MAX32;
      magov_nxt = 1'b1;
    end else begin
      mag_nxt   = rr[31:0];
      magov_nxt = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      am[i] = side_r[ST_POST-1].a[i][31] ? (32'd0 - side_r[ST_POST-1].a[i])
                                          : side_r[ST_POST-1].a[i];
      num_nxt[i] = ({32'd0, am[i]} << (FRAC_BITS + int'(side_r[ST_POST-1].h)))
                 + {33'd0, sq_root[31:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_POST]) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= num_nxt[i];
      end
      den_r <= sq_root;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3mu_div u_div (
      .clk (clk),
      .en  (en[ST_OUT-1:ST_DIV]),
      .num (num_r[i]),
      .den (den_r),
      .q   (dq[i])
    );
  end

  // result select
  always_comb begin
    sd        = side_r[ST_OUT-1];
    zero_vec  = (sd.a == '0);
    o_res_nxt = '0;
    o_zl_nxt  = 1'b0;
    o_ov_nxt  = 1'b0;
    qv        = '0;
    case (sd.mode)
      MODE_ADD, MODE_SUB, MODE_NEG, MODE_SCALE,
      MODE_ADDK, MODE_ELEM, MODE_CROSS, MODE_DOT: begin
        o_res_nxt = sd.res;
        o_ov_nxt  = sd.ov;
      end
      MODE_MAG, MODE_DIST: begin
        o_res_nxt[0] = sd.mag;
        o_ov_nxt     = sd.magov;
      end
      MODE_NORM: begin
        if (zero_vec) begin
          o_res_nxt = sd.a;
          o_zl_nxt  = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            qv           = {{(32 - QW){1'b0}}, dq[i]};
            o_res_nxt[i] = sd.a[i][31] ? (32'd0 - qv) : qv;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      o_res_r <= o_res_nxt;
      o_zl_r  <= o_zl_nxt;
      o_ov_r  <= o_ov_nxt;
    end
  end

  assign out_res.valid       = v_r[NST-1];
  assign out_res.res_x       = o_res_r[0];
  assign out_res.res_y       = o_res_r[1];
  assign out_res.res_z       = o_res_r[2];
  assign out_res.zero_length = o_zl_r;
  assign out_res.overflow    = o_ov_r;

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (out_res.valid && !out_res.ready))
    else $error("input stalled while output can move");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.zero_length) |->
      (!out_res.overflow && out_res.res_x == 0 && out_res.res_y == 0 && out_res.res_z == 0))
    else $error("zero length result not clean");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_res.valid)
    else $error("output valid after reset");

endmodule

FILE: tb/vector3_math_unit_tb.sv
`timescale 1ns / 1ps
module vector3_math_unit_tb;
  import v3mu_pkg::*;

  localparam int  NUM_RANDOM   = 1000;
  localparam int  DRAIN_CYCLES = 80;
  localparam logic [3:0] MODE_UNUSED_LO = 4'd11;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;
  localparam longint LMAX = 64'sh7fffffffffffffff;
  localparam longint LMIN = 64'sh8000000000000000;

  typedef struct {
    logic [3:0]         mode;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] k;
  } vreq_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zl;
    logic               ov;
  } vres_t;

  typedef struct {
    vreq_t req;
    bit    typed;
    vres_t res;
  } vrow_t;

  logic clk;
  logic rst_n;

  v3mu_in_if  in_req ();
  v3mu_out_if out_res ();

  vector3_math_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  vres_t results_due [$];
  vrow_t vec_rows    [$];
  int    send_gap_pct;
  int    recv_stall_pct;
  int    mismatches;
  int    results_seen;
  int    mode_hits [16];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp_wide(logic signed [65:0] t);
    if (t > LMAX) begin
      return LMAX;
    end
    if (t < LMIN) begin
      return LMIN;
    end
    return longint'(t);
  endfunction

  function automatic logic signed [31:0] sat_word(longint v, inout logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return MAX32;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return MIN32;
    end
    return v[31:0];
  endfunction

  // floor shift plus the bit below the point
  function automatic longint round_shift(longint p);
    longint fl;
    fl = p >>> FRAC_BITS;
    return fl + longint'(p[FRAC_BITS-1]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bt;
    root = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= root + bt) begin
        n = n - (root + bt);
        root = (root >> 1) + bt;
      end else begin
        root = root >> 1;
      end
      bt = bt >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned abs_wide(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint vec_length(longint d [3], inout logic ov);
    longint unsigned s;
    longint unsigned m;
    longint unsigned r;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = abs_wide(d[i]);
      if (m > 64'h80000000) begin
        ov = 1'b1;
        return 64'sd2147483647;
      end
      s = s + m * m;
    end
    r = int_sqrt(s);
    if (s - r * r > r) r = r + 1;
    if (r > 64'd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(r);
  endfunction

  function automatic vres_t vector_result(vreq_t q);
    vres_t o;
    longint a [3];
    longint b [3];
    longint d [3];
    longint r [3];
    longint k;
    longint p;
    logic signed [65:0] t;
    logic ov;
    logic zl;
    longint unsigned s;
    longint unsigned root;
    longint unsigned n;
    longint unsigned quo;
    longint v;
    int h;
    int j;
    int m;
    ov = 1'b0;
    zl = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = q.a[i];
      b[i] = q.b[i];
      r[i] = 0;
    end
    k = q.k;
    case (q.mode)
      MODE_ADD: for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] + b[i], ov);
      MODE_SUB: for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] - b[i], ov);
      MODE_NEG: for (int i = 0; i < 3; i++) r[i] = sat_word(-a[i], ov);
      MODE_SCALE: for (int i = 0; i < 3; i++) r[i] = sat_word(round_shift(a[i] * k), ov);
      MODE_ADDK: for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] + k, ov);
      MODE_ELEM: for (int i = 0; i < 3; i++) r[i] = sat_word(round_shift(a[i] * b[i]), ov);
      MODE_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          m = (i + 2) % 3;
          t = a[j] * b[m];
          t = t - a[m] * b[j];
          r[i] = sat_word(round_shift(clamp_wide(t)), ov);
        end
      end
      MODE_DOT: begin
        t = a[0] * b[0];
        t = t + a[1] * b[1];
        p = clamp_wide(t);
        t = p;
        t = t + a[2] * b[2];
        r[0] = sat_word(round_shift(clamp_wide(t)), ov);
      end
      MODE_MAG: r[0] = vec_length(a, ov);
      MODE_DIST: begin
        for (int i = 0; i < 3; i++) d[i] = a[i] - b[i];
        r[0] = vec_length(d, ov);
      end
      MODE_NORM: begin
        s = 0;
        for (int i = 0; i < 3; i++) s = s + abs_wide(a[i]) * abs_wide(a[i]);
        if (s == 0) begin
          zl = 1'b1;
          for (int i = 0; i < 3; i++) r[i] = a[i];
        end else begin
          h = 0;
          while (h < HMAX && (s >> (62 - 2 * h)) == 0) h++;
          root = int_sqrt(s << (2 * h));
          for (int i = 0; i < 3; i++) begin
            n = abs_wide(a[i]) << (FRAC_BITS + h);
            quo = (n + root / 2) / root;
            v = quo > 64'h100000000 ? 64'sh100000000 : longint'(quo);
            r[i] = sat_word(a[i] < 0 ? -v : v, ov);
          end
        end
      end
      default: ;
    endcase
    o.x = r[0][31:0];
    o.y = r[1][31:0];
    o.z = r[2][31:0];
    o.zl = zl;
    o.ov = ov;
    return o;
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return MAX32;
      1: return MIN32;
      2: return 32'sd0;
      3: return $urandom_range(0, 4) - 2;
      4, 5: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
      6: return $signed($urandom_range(0, 32'hffffff)) - 32'sh800000;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_row(logic [3:0] md, logic signed [31:0] ax, logic signed [31:0] ay,
                         logic signed [31:0] az, logic signed [31:0] bx,
                         logic signed [31:0] by, logic signed [31:0] bz,
                         logic signed [31:0] kk, bit typed, logic signed [31:0] ex,
                         logic signed [31:0] ey, logic signed [31:0] ez, logic ezl,
                         logic eov);
    vrow_t row;
    row.req.mode = md;
    row.req.a[0] = ax;
    row.req.a[1] = ay;
    row.req.a[2] = az;
    row.req.b[0] = bx;
    row.req.b[1] = by;
    row.req.b[2] = bz;
    row.req.k = kk;
    row.typed = typed;
    row.res.x = ex;
    row.res.y = ey;
    row.res.z = ez;
    row.res.zl = ezl;
    row.res.ov = eov;
    vec_rows.push_back(row);
  endtask

  task automatic send_request(vreq_t q, bit typed, vres_t known);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_gap_pct) @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.mode     <= q.mode;
    in_req.a_x      <= q.a[0];
    in_req.a_y      <= q.a[1];
    in_req.a_z      <= q.a[2];
    in_req.b_x      <= q.b[0];
    in_req.b_y      <= q.b[1];
    in_req.b_z      <= q.b[2];
    in_req.scalar_k <= q.k;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    results_due.push_back(typed ? known : vector_result(q));
    mode_hits[q.mode]++;
  endtask

  initial begin
    vreq_t q;
    vres_t none;
    int cap;
    rst_n = 1'b0;
    clk = 1'b0;
    mismatches = 0;
    results_seen = 0;
    send_gap_pct = 19;
    recv_stall_pct = 83;
    foreach (mode_hits[i]) mode_hits[i] = 0;
    none = '{default: '0};
    in_req.valid    <= 1'b0;
    in_req.mode     <= '0;
    in_req.a_x      <= '0;
    in_req.a_y      <= '0;
    in_req.a_z      <= '0;
    in_req.b_x      <= '0;
    in_req.b_y      <= '0;
    in_req.b_z      <= '0;
    in_req.scalar_k <= '0;
    add_row(MODE_ADD, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, 0, 1, MAX32, MAX32, MAX32, 0, 1);
    add_row(MODE_SUB, MIN32, MIN32, MIN32, MAX32, MAX32, MAX32, 0, 1, MIN32, MIN32, MIN32, 0, 1);
    add_row(MODE_NEG, MIN32, MIN32, MIN32, 0, 0, 0, 0, 1, MAX32, MAX32, MAX32, 0, 1);
    add_row(MODE_NEG, 0, 0, 0, -1, -1, -1, -1, 1, 0, 0, 0, 0, 0);
    add_row(MODE_SCALE, 1, -1, 32'sh30000, 0, 0, 0, 32'sh8000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_SCALE, MIN32, MAX32, -1, 0, 0, 0, MIN32, 0, 0, 0, 0, 0, 0);
    add_row(MODE_ADDK, MAX32, MIN32, 5, 0, 0, 0, MAX32, 0, 0, 0, 0, 0, 0);
    add_row(MODE_ELEM, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, 0,
            1, MAX32, MAX32, MAX32, 0, 1);
    add_row(MODE_ELEM, 32'sh18000, -32'sh8000, 7, 32'sh20000, 32'sh10001, -3, 0,
            0, 0, 0, 0, 0, 0);
    add_row(MODE_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_CROSS, MIN32, MAX32, MIN32, MAX32, MIN32, MIN32, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DOT, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DOT, MIN32, MIN32, MAX32, MIN32, MIN32, MIN32, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_MAG, 3, 4, 0, 0, 0, 0, 0, 1, 5, 0, 0, 0, 0);
    add_row(MODE_MAG, MIN32, MIN32, MIN32, 0, 0, 0, 0, 1, MAX32, 0, 0, 0, 1);
    add_row(MODE_DIST, MAX32, 0, 0, MIN32, 0, 0, 0, 1, MAX32, 0, 0, 0, 1);
    add_row(MODE_DIST, 32'sh50000, 32'sh10000, -2, 32'sh20000, -32'sh30000, 9, 0,
            0, 0, 0, 0, 0, 0);
    add_row(MODE_NORM, 0, 0, 0, 7, 7, 7, 7, 1, 0, 0, 0, 1, 0);
    add_row(MODE_NORM, 32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_NORM, 1, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_NORM, MIN32, MIN32, MAX32, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_UNUSED_LO, MAX32, 1, 2, 3, 4, 5, 6, 1, 0, 0, 0, 0, 0);
    add_row(MODE_UNUSED_HI, MIN32, -1, -1, -1, -1, -1, -1, 1, 0, 0, 0, 0, 0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (vec_rows[i]) send_request(vec_rows[i].req, vec_rows[i].typed, vec_rows[i].res);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        send_gap_pct = 83;
        recv_stall_pct = 19;
      end else if (n == 2 * NUM_RANDOM / 3) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      q.mode = $urandom_range(0, 19) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      for (int i = 0; i < 3; i++) begin
        q.a[i] = pick_word();
        q.b[i] = pick_word();
      end
      q.k = pick_word();
      if (q.mode == MODE_NORM && $urandom_range(0, 9) == 0) begin
        q.a[0] = 0;
        q.a[1] = 0;
        q.a[2] = 0;
      end
      send_request(q, 0, none);
    end
    in_req.valid <= 1'b0;
    cap = 0;
    while (results_due.size() != 0 && cap < 200000) begin
      @(posedge clk);
      cap++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0d results never arrived", results_due.size());
      mismatches += results_due.size();
    end
    $display("checked %0d results over %0d directed and %0d random requests",
             results_seen, vec_rows.size(), NUM_RANDOM);
    $display("per mode: %p", mode_hits);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    vres_t e;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%h", out_res.res_x);
        end else begin
          e = results_due.pop_front();
          if (out_res.res_x !== e.x || out_res.res_y !== e.y || out_res.res_z !== e.z ||
              out_res.zero_length !== e.zl || out_res.overflow !== e.ov) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected %h %h %h zl=%b ov=%b, got %h %h %h zl=%b ov=%b",
                       e.x, e.y, e.z, e.zl, e.ov, out_res.res_x, out_res.res_y,
                       out_res.res_z, out_res.zero_length, out_res.overflow);
            end
          end
        end
      end
      out_res.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: vector3_math_unit.f
rtl/v3mu_pkg.sv
rtl/v3mu_in_if.sv
rtl/v3mu_out_if.sv
rtl/v3mu_lane.sv
rtl/v3mu_merge.sv
rtl/v3mu_sqrt.sv
rtl/v3mu_div.sv
rtl/vector3_math_unit.sv
tb/vector3_math_unit_tb.sv
